>>> rtl/bez_pkg.sv
// Shared types and constants for the cubic Bezier point generator.
// Used by every module of the block; depends on nothing else.
package bez_pkg;

    // Field and datapath widths.
    localparam int SEG_W      = 6;
    localparam int COORD_W    = 16;
    localparam int WGT_W      = 17;
    localparam int QUO_W      = 17;
    localparam int OPND_W     = 18;
    localparam int PROD_W     = 36;
    localparam int ACC_W      = 36;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // Largest segment count that the input field can carry.
    localparam int MAX_SEGMENTS = 63;

    // One in Q1.16.
    localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

    // Control point register indexes, at byte address 4*index.
    typedef enum logic [2:0] {
        REG_P0_X = 3'd0,
        REG_P0_Y = 3'd1,
        REG_P1_X = 3'd2,
        REG_P1_Y = 3'd3,
        REG_P2_X = 3'd4,
        REG_P2_Y = 3'd5,
        REG_P3_X = 3'd6,
        REG_P3_Y = 3'd7
    } reg_idx_e;

    // Reset values of the control points, signed Q11.4.
    localparam logic [COORD_W-1:0] P0_X_RST = 16'd320;
    localparam logic [COORD_W-1:0] P0_Y_RST = 16'd1600;
    localparam logic [COORD_W-1:0] P1_X_RST = 16'd480;
    localparam logic [COORD_W-1:0] P1_Y_RST = 16'd1760;
    localparam logic [COORD_W-1:0] P2_X_RST = 16'd800;
    localparam logic [COORD_W-1:0] P2_Y_RST = 16'd1440;
    localparam logic [COORD_W-1:0] P3_X_RST = 16'd960;
    localparam logic [COORD_W-1:0] P3_Y_RST = 16'd1600;

    // A prepared request: segment count plus the parameter step 65536/S
    // split into quotient and remainder.
    typedef struct packed {
        logic [SEG_W-1:0] segs;
        logic [QUO_W-1:0] q_step;
        logic [SEG_W-1:0] r_step;
    } job_t;

    // The four control points as two's complement words.
    typedef struct packed {
        logic [COORD_W-1:0] p0_x;
        logic [COORD_W-1:0] p0_y;
        logic [COORD_W-1:0] p1_x;
        logic [COORD_W-1:0] p1_y;
        logic [COORD_W-1:0] p2_x;
        logic [COORD_W-1:0] p2_y;
        logic [COORD_W-1:0] p3_x;
        logic [COORD_W-1:0] p3_y;
    } ctrl_pts_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

>>> rtl/bez_fifo.sv
// Two-entry job queue between the request front end and the point engine.
// Depends on bez_pkg for the job type and queue depth.
module bez_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bez_pkg::job_t      wr_data,
    input  logic               pop,
    output bez_pkg::job_t      rd_data,
    output bez_pkg::fifo_stat_t stat
);
    import bez_pkg::*;

    job_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign stat.full  = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/bez_front.sv
// Request front end: takes segment counts, drops empty requests and works
// out 65536/S bit by bit before queueing the job. Depends on bez_pkg.
module bez_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bez_pkg::SEG_W-1:0]  segments,
    input  bez_pkg::fifo_stat_t        fstat,
    output logic                       push,
    output bez_pkg::job_t              job
);
    import bez_pkg::*;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } fstate_e;

    localparam logic [4:0] DIV_LAST = 5'(QUO_W - 1);

    fstate_e          state_reg, state_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [SEG_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [SEG_W:0]   trial;
    logic [SEG_W:0]   diff;
    logic             fits;

    assign in_ready = (state_reg == FS_IDLE);
    assign push     = (state_reg == FS_PUSH) && !fstat.full;
    assign job      = '{segs: seg_reg, q_step: quo_reg, r_step: rem_reg};

    // One restoring division step: the dividend is 1 followed by sixteen zeros.
    assign trial = {rem_reg, (cnt_reg == DIV_LAST)};
    assign diff  = trial - {1'b0, seg_reg};
    assign fits  = (trial >= {1'b0, seg_reg});

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                // A zero count is taken and produces nothing.
                if (in_valid && (segments != '0))
                begin
                    seg_next   = segments;
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = DIV_LAST;
                    state_next = FS_DIV;
                end
            end
            FS_DIV:
            begin
                rem_next = fits ? diff[SEG_W-1:0] : trial[SEG_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], fits};
                if (cnt_reg == '0)
                begin
                    state_next = FS_PUSH;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            FS_PUSH:
            begin
                if (!fstat.full)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Division datapath registers.
    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

endmodule

>>> rtl/bez_engine.sv
// Point engine: walks k = 0..S for one queued job, forms the Bernstein
// weights and both coordinates on one shared multiplier. Depends on bez_pkg.
module bez_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bez_pkg::ctrl_pts_t           pts,
    input  bez_pkg::job_t                job,
    input  bez_pkg::fifo_stat_t          fstat,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bez_pkg::COORD_W-1:0]  curve_x,
    output logic [bez_pkg::COORD_W-1:0]  curve_y,
    output logic [bez_pkg::SEG_W-1:0]    point_index,
    output logic                         last
);
    import bez_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } estate_e;

    // Multiplier schedule for one point, one product per cycle.
    typedef enum logic [3:0] {
        OP_UU,
        OP_VV,
        OP_UUU,
        OP_VVV,
        OP_UVV,
        OP_UUV,
        OP_X0,
        OP_Y0,
        OP_X3,
        OP_Y3,
        OP_X1,
        OP_Y1,
        OP_X2,
        OP_Y2,
        OP_DRAIN
    } op_e;

    localparam int SHR_W = ACC_W - 16;
    localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'(32767);
    localparam logic signed [SHR_W-1:0] SAT_MIN = -SHR_W'(32768);

    estate_e            state_reg, state_next;
    op_e                op_reg, op_next;
    op_e                wb_op_reg;
    logic               wb_vld_reg;
    logic [SEG_W-1:0]   seg_reg, seg_next;
    logic [QUO_W-1:0]   qs_reg, qs_next;
    logic [SEG_W-1:0]   rs_reg, rs_next;
    logic [SEG_W-1:0]   k_reg, k_next;
    logic [WGT_W-1:0]   u_reg, u_next;
    logic [SEG_W-1:0]   r_reg, r_next;
    logic [WGT_W-1:0]   u2_reg, v2_reg, u3_reg, v3_reg, w1_reg, w2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  accx_reg, accy_reg;
    logic               acc_clr;
    logic               out_load;
    logic               outv_reg, outv_next;
    logic [COORD_W-1:0] cx_reg, cy_reg;
    logic [SEG_W-1:0]   idx_reg;
    logic               last_reg;

    logic [WGT_W-1:0]         v_val;
    logic signed [OPND_W-1:0] mul_a;
    logic [WGT_W-1:0]         mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [WGT_W-1:0]         wgt;
    logic [WGT_W:0]           wgt3;
    logic [SEG_W:0]           r_sum;
    logic                     carry;
    logic signed [SHR_W-1:0]  shx, shy;
    logic [COORD_W-1:0]       satx, saty;
    logic                     is_last;

    function automatic logic signed [OPND_W-1:0] sx(input logic [COORD_W-1:0] p);
        return {{(OPND_W-COORD_W){p[COORD_W-1]}}, p};
    endfunction

    function automatic logic signed [OPND_W-1:0] zx(input logic [WGT_W-1:0] w);
        return {{(OPND_W-WGT_W){1'b0}}, w};
    endfunction

    function automatic logic [COORD_W-1:0] sat(input logic signed [SHR_W-1:0] s);
        logic [COORD_W-1:0] r;
        if (s > SAT_MAX)
        begin
            r = SAT_MAX[COORD_W-1:0];
        end
        else if (s < SAT_MIN)
        begin
            r = SAT_MIN[COORD_W-1:0];
        end
        else
        begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

    assign v_val       = ONE_Q16 - u_reg;
    assign pop         = (state_reg == ST_IDLE) && !fstat.empty;
    assign out_valid   = outv_reg;
    assign curve_x     = cx_reg;
    assign curve_y     = cy_reg;
    assign point_index = idx_reg;
    assign last        = last_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_UU:    begin mul_a = zx(u_reg);   mul_b = u_reg;  end
            OP_VV:    begin mul_a = zx(v_val);   mul_b = v_val;  end
            OP_UUU:   begin mul_a = zx(u2_reg);  mul_b = u_reg;  end
            OP_VVV:   begin mul_a = zx(v2_reg);  mul_b = v_val;  end
            OP_UVV:   begin mul_a = zx(u_reg);   mul_b = v2_reg; end
            OP_UUV:   begin mul_a = zx(u2_reg);  mul_b = v_val;  end
            OP_X0:    begin mul_a = sx(pts.p0_x); mul_b = v3_reg; end
            OP_Y0:    begin mul_a = sx(pts.p0_y); mul_b = v3_reg; end
            OP_X3:    begin mul_a = sx(pts.p3_x); mul_b = u3_reg; end
            OP_Y3:    begin mul_a = sx(pts.p3_y); mul_b = u3_reg; end
            OP_X1:    begin mul_a = sx(pts.p1_x); mul_b = w1_reg; end
            OP_Y1:    begin mul_a = sx(pts.p1_y); mul_b = w1_reg; end
            OP_X2:    begin mul_a = sx(pts.p2_x); mul_b = w2_reg; end
            OP_Y2:    begin mul_a = sx(pts.p2_y); mul_b = w2_reg; end
            default:  begin mul_a = '0;          mul_b = '0;     end
        endcase
    end

    assign mul_p = mul_a * zx(mul_b);

    // Truncated weight from the registered product, and three times it.
    assign wgt  = prod_reg[WGT_W+15:16];
    assign wgt3 = {1'b0, wgt} + {wgt, 1'b0};

    // Next parameter value: u advances by q_step plus a carry from the
    // running remainder, which stays below twice S.
    assign r_sum = {1'b0, r_reg} + {1'b0, rs_reg};
    assign carry = (r_sum >= {1'b0, seg_reg});

    // Floor shift by sixteen and saturation of both sums.
    assign shx     = accx_reg[ACC_W-1:16];
    assign shy     = accy_reg[ACC_W-1:16];
    assign satx    = sat(shx);
    assign saty    = sat(shy);
    assign is_last = (k_reg == seg_reg);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        seg_next   = seg_reg;
        qs_next    = qs_reg;
        rs_next    = rs_reg;
        k_next     = k_reg;
        u_next     = u_reg;
        r_next     = r_reg;
        acc_clr    = 1'b0;
        out_load   = 1'b0;
        outv_next  = outv_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fstat.empty)
                begin
                    seg_next   = job.segs;
                    qs_next    = job.q_step;
                    rs_next    = job.r_step;
                    k_next     = '0;
                    u_next     = '0;
                    r_next     = '0;
                    op_next    = OP_UU;
                    acc_clr    = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (op_reg == OP_DRAIN)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    op_next = op_e'(op_reg + 1'b1);
                end
            end
            ST_EMIT:
            begin
                if (!outv_reg || out_ready)
                begin
                    out_load  = 1'b1;
                    outv_next = 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        r_next     = carry ? SEG_W'(r_sum - {1'b0, seg_reg})
                                           : r_sum[SEG_W-1:0];
                        u_next     = u_reg + qs_reg + {{(WGT_W-1){1'b0}}, carry};
                        op_next    = OP_UU;
                        acc_clr    = 1'b1;
                        state_next = ST_CALC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_DRAIN;
            wb_vld_reg <= 1'b0;
            outv_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            wb_vld_reg <= (state_reg == ST_CALC) && (op_reg != OP_DRAIN);
            outv_reg   <= outv_next;
        end
    end

    // Datapath registers: product, weights, sums and job bookkeeping.
    always_ff @(posedge clk)
    begin
        seg_reg   <= seg_next;
        qs_reg    <= qs_next;
        rs_reg    <= rs_next;
        k_reg     <= k_next;
        u_reg     <= u_next;
        r_reg     <= r_next;
        prod_reg  <= mul_p;
        wb_op_reg <= op_reg;
        if (acc_clr)
        begin
            accx_reg <= '0;
            accy_reg <= '0;
        end
        else if (wb_vld_reg)
        begin
            case (wb_op_reg) inside
                OP_UU:  u2_reg <= wgt;
                OP_VV:  v2_reg <= wgt;
                OP_UUU: u3_reg <= wgt;
                OP_VVV: v3_reg <= wgt;
                OP_UVV: w1_reg <= wgt3[WGT_W-1:0];
                OP_UUV: w2_reg <= wgt3[WGT_W-1:0];
                OP_X0, OP_X3, OP_X1, OP_X2:
                    accx_reg <= accx_reg + prod_reg;
                OP_Y0, OP_Y3, OP_Y1, OP_Y2:
                    accy_reg <= accy_reg + prod_reg;
                default:
                begin
                end
            endcase
        end
        if (out_load)
        begin
            cx_reg   <= satx;
            cy_reg   <= saty;
            idx_reg  <= k_reg;
            last_reg <= is_last;
        end
    end

endmodule

>>> rtl/cubic_bezier_point_generator_top.sv
// Top level of the cubic Bezier point generator: control point registers,
// APB access, request front end, job queue and point engine. Uses bez_pkg.
//
// A request carrying a segment count S (1..63) yields S+1 curve points, one
// beat each, with the sample index and a last flag on the final beat; a count
// of zero is taken and yields nothing. Each point is formed in turn on the
// single 18x18 multiplier, which forms six weight products and eight coordinate
// products, and a request occupies the engine for its S+1 points plus a job
// fetch. The front end divides 65536 by S one quotient bit a cycle,
// overlapped with the previous request through a two-entry job queue. The
// user must write control points over APB only while the block is idle; the
// block itself does not enforce this. A result beat waiting on the output
// does not stop work on the next point until that point is ready to be shown.
module cubic_bezier_point_generator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bez_pkg::ADDR_W-1:0]    paddr,
    input  logic [bez_pkg::DATA_W-1:0]    pwdata,
    output logic [bez_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bez_pkg::SEG_W-1:0]     segments,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bez_pkg::COORD_W-1:0]   curve_x,
    output logic [bez_pkg::COORD_W-1:0]   curve_y,
    output logic [bez_pkg::SEG_W-1:0]     point_index,
    output logic                          last
);
    import bez_pkg::*;

    ctrl_pts_t  pts_reg;
    reg_idx_e   reg_idx;
    logic       cfg_wr;
    logic       push;
    logic       pop;
    job_t       wr_job;
    job_t       rd_job;
    fifo_stat_t fstat;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Control point registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg.p0_x <= P0_X_RST;
            pts_reg.p0_y <= P0_Y_RST;
            pts_reg.p1_x <= P1_X_RST;
            pts_reg.p1_y <= P1_Y_RST;
            pts_reg.p2_x <= P2_X_RST;
            pts_reg.p2_y <= P2_Y_RST;
            pts_reg.p3_x <= P3_X_RST;
            pts_reg.p3_y <= P3_Y_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_P0_X: pts_reg.p0_x <= pwdata[COORD_W-1:0];
                REG_P0_Y: pts_reg.p0_y <= pwdata[COORD_W-1:0];
                REG_P1_X: pts_reg.p1_x <= pwdata[COORD_W-1:0];
                REG_P1_Y: pts_reg.p1_y <= pwdata[COORD_W-1:0];
                REG_P2_X: pts_reg.p2_x <= pwdata[COORD_W-1:0];
                REG_P2_Y: pts_reg.p2_y <= pwdata[COORD_W-1:0];
                REG_P3_X: pts_reg.p3_x <= pwdata[COORD_W-1:0];
                REG_P3_Y: pts_reg.p3_y <= pwdata[COORD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_P0_X: prdata = {{(DATA_W-COORD_W){1'b0}}, pts_reg.p0_x};
            REG_P0_Y: prdata = {{(DATA_W-COORD_W){1'b0}}, pts_reg.p0_y};
            REG_P1_X: prdata = {{(DATA_W-COORD_W){1'b0}}, pts_reg.p1_x};
            REG_P1_Y: prdata = {{(DATA_W-COORD_W){1'b0}}, pts_reg.p1_y};
            REG_P2_X: prdata = {{(DATA_W-COORD_W){1'b0}}, pts_reg.p2_x};
            REG_P2_Y: prdata = {{(DATA_W-COORD_W){1'b0}}, pts_reg.p2_y};
            REG_P3_X: prdata = {{(DATA_W-COORD_W){1'b0}}, pts_reg.p3_x};
            REG_P3_Y: prdata = {{(DATA_W-COORD_W){1'b0}}, pts_reg.p3_y};
            default:  prdata = '0;
        endcase
    end

    // Request front end.
    bez_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .segments (segments),
        .fstat    (fstat),
        .push     (push),
        .job      (wr_job)
    );

    // Job queue.
    bez_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_job),
        .pop     (pop),
        .rd_data (rd_job),
        .stat    (fstat)
    );

    // Point engine.
    bez_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .pts         (pts_reg),
        .job         (rd_job),
        .fstat       (fstat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .point_index (point_index),
        .last        (last)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fstat.full)
        else $error("job pushed into a full queue");

    // The engine never takes a job from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fstat.empty)
        else $error("job popped from an empty queue");

    // Every request has at least one segment, so its final beat is never index zero.
    a_last_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (point_index != '0))
        else $error("final beat carries index zero");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the cubic Bezier point generator.
// Drives segment requests and APB control point writes, predicts every curve
// point and checks each output beat. Depends on bez_pkg and the top level RTL.
module tb_top;

    import bez_pkg::*;

    // One expected curve point.
    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SEG_W-1:0]   idx;
        logic               is_last;
    } curve_pt_t;

    // Ways of choosing a control point setting.
    typedef enum int {
        PTS_RANDOM,
        PTS_EXTREME,
        PTS_NEAR_ZERO
    } pts_mode_e;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [SEG_W-1:0]    segments = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [COORD_W-1:0]  curve_x;
    logic [COORD_W-1:0]  curve_y;
    logic [SEG_W-1:0]    point_index;
    logic                last;

    // Requests waiting to be driven and points waiting to come out.
    logic [SEG_W-1:0]    seg_q[$];
    curve_pt_t           point_q[$];

    // Control points as the block should currently hold them.
    ctrl_pts_t           ctrl_model;

    // Set during one stretch of the run to turn off all random gaps.
    bit                  no_gaps = 1'b0;
    int                  err_count = 0;

    cubic_bezier_point_generator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .segments    (segments),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .point_index (point_index),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Weighted sum of four control point coordinates, floored and saturated.
    function automatic logic [COORD_W-1:0] blend_coord(longint w0, longint w1, longint w2,
                                                       longint w3, logic [COORD_W-1:0] a,
                                                       logic [COORD_W-1:0] b,
                                                       logic [COORD_W-1:0] c,
                                                       logic [COORD_W-1:0] d);
        longint acc;
        acc = longint'($signed(a)) * w0 + longint'($signed(b)) * w1
            + longint'($signed(c)) * w2 + longint'($signed(d)) * w3;
        acc = acc >>> 16;
        if (acc > 32767)
            acc = 32767;
        else if (acc < -32768)
            acc = -32768;
        return acc[COORD_W-1:0];
    endfunction

    // Point k of a request with s segments, Bernstein weights truncated in Q1.16.
    function automatic curve_pt_t bezier_point(ctrl_pts_t cp, int unsigned k, int unsigned s);
        longint unsigned u, v, u2, u3, v2, v3;
        longint          w0, w1, w2, w3;
        curve_pt_t       pt;
        u  = (longint'(k) * 65536) / s;
        v  = 65536 - u;
        u2 = (u * u) >> 16;
        u3 = (u2 * u) >> 16;
        v2 = (v * v) >> 16;
        v3 = (v2 * v) >> 16;
        w0 = longint'(v3);
        w1 = longint'(3 * ((u * v2) >> 16));
        w2 = longint'(3 * ((u2 * v) >> 16));
        w3 = longint'(u3);
        pt.x       = blend_coord(w0, w1, w2, w3, cp.p0_x, cp.p1_x, cp.p2_x, cp.p3_x);
        pt.y       = blend_coord(w0, w1, w2, w3, cp.p0_y, cp.p1_y, cp.p2_y, cp.p3_y);
        pt.idx     = k[SEG_W-1:0];
        pt.is_last = (k == s);
        return pt;
    endfunction

    // Value that one control point register should hold.
    function automatic logic [COORD_W-1:0] ctrl_field(ctrl_pts_t cp, reg_idx_e r);
        case (r)
            REG_P0_X: return cp.p0_x;
            REG_P0_Y: return cp.p0_y;
            REG_P1_X: return cp.p1_x;
            REG_P1_Y: return cp.p1_y;
            REG_P2_X: return cp.p2_x;
            REG_P2_Y: return cp.p2_y;
            REG_P3_X: return cp.p3_x;
            default:  return cp.p3_y;
        endcase
    endfunction

    // Request driver: one beat per accepted segment count, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        logic             nxt_valid;
        logic [SEG_W-1:0] nxt_seg;
        int unsigned      s;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            segments <= '0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_seg   = segments;
            if (in_valid && in_ready)
            begin
                // A zero count is taken but yields no points.
                s = segments;
                for (int unsigned k = 0; s != 0 && k <= s; k++)
                    point_q.push_back(bezier_point(ctrl_model, k, s));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && seg_q.size() != 0 && (no_gaps || $urandom_range(99) >= 6))
            begin
                nxt_valid = 1'b1;
                nxt_seg   = seg_q.pop_front();
            end
            in_valid <= nxt_valid;
            segments <= nxt_seg;
        end
    end

    // Point monitor: random back pressure and a field-by-field check of each beat.
    always @(posedge clk or negedge rst_n)
    begin
        curve_pt_t pt;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (point_q.size() == 0)
                begin
                    $error("unexpected point beat: index %0d", point_index);
                    err_count++;
                end
                else
                begin
                    pt = point_q.pop_front();
                    if (curve_x !== pt.x)
                    begin
                        $error("curve_x expected %0d got %0d", $signed(pt.x), $signed(curve_x));
                        err_count++;
                    end
                    if (curve_y !== pt.y)
                    begin
                        $error("curve_y expected %0d got %0d", $signed(pt.y), $signed(curve_y));
                        err_count++;
                    end
                    if (point_index !== pt.idx)
                    begin
                        $error("point_index expected %0d got %0d", pt.idx, point_index);
                        err_count++;
                    end
                    if (last !== pt.is_last)
                    begin
                        $error("last expected %0d got %0d", pt.is_last, last);
                        err_count++;
                    end
                end
            end
            out_ready <= no_gaps || ($urandom_range(99) >= 6);
        end
    end

    // APB write of one control point register; upper data bits are random junk.
    task automatic apb_write(reg_idx_e r, logic [COORD_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {16'($urandom_range(65535)), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_P0_X: ctrl_model.p0_x = val;
            REG_P0_Y: ctrl_model.p0_y = val;
            REG_P1_X: ctrl_model.p1_x = val;
            REG_P1_Y: ctrl_model.p1_y = val;
            REG_P2_X: ctrl_model.p2_x = val;
            REG_P2_Y: ctrl_model.p2_y = val;
            REG_P3_X: ctrl_model.p3_x = val;
            default:  ctrl_model.p3_y = val;
        endcase
    endtask

    // APB read of one register, checked against the model during the access phase.
    task automatic apb_check(reg_idx_e r);
        logic [DATA_W-1:0] rd;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rd = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[COORD_W-1:0] !== ctrl_field(ctrl_model, r))
        begin
            $error("%s expected %0d got %0d", r.name(), $signed(ctrl_field(ctrl_model, r)),
                   $signed(rd[COORD_W-1:0]));
            err_count++;
        end
    endtask

    // Load a full control point setting and read every register back.
    task automatic load_ctrl(ctrl_pts_t cp);
        reg_idx_e r;
        r = r.first();
        repeat (r.num())
        begin
            apb_write(r, ctrl_field(cp, r));
            r = r.next();
        end
        r = r.first();
        repeat (r.num())
        begin
            apb_check(r);
            r = r.next();
        end
    endtask

    // Pick a control point setting of the given kind.
    function automatic ctrl_pts_t pick_ctrl(pts_mode_e mode);
        ctrl_pts_t cp;
        logic [COORD_W-1:0] f[8];
        foreach (f[i])
        begin
            case (mode)
                PTS_EXTREME:   f[i] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                PTS_NEAR_ZERO: f[i] = 16'($signed($urandom_range(64)) - 32);
                default:       f[i] = 16'($urandom_range(65535));
            endcase
        end
        cp = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]};
        return cp;
    endfunction

    // Wait until every request is in and every point is out, then let the
    // front end finish any zero-count requests still in flight.
    task automatic wait_drained();
        while (seg_q.size() != 0 || in_valid || point_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Stimulus sequence: directed settings first, then random phases.
    initial
    begin
        ctrl_pts_t cp;
        int        taken;
        ctrl_model = '{p0_x: P0_X_RST, p0_y: P0_Y_RST, p1_x: P1_X_RST, p1_y: P1_Y_RST,
                       p2_x: P2_X_RST, p2_y: P2_Y_RST, p3_x: P3_X_RST, p3_y: P3_Y_RST};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset control points: smallest and largest counts, an ignored zero.
        seg_q = '{6'd1, 6'd2, 6'd3, 6'd63, 6'd0, 6'd7};
        wait_drained();

        // All control points at the positive limit.
        cp = {8{16'h7FFF}};
        load_ctrl(cp);
        seg_q = '{6'd63, 6'd1, 6'd5};
        wait_drained();

        // All control points at the negative limit.
        cp = {8{16'h8000}};
        load_ctrl(cp);
        seg_q = '{6'd63, 6'd4, 6'd0, 6'd16};
        wait_drained();

        // Alternating limits, which give the largest swings of the sum.
        cp = {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
        load_ctrl(cp);
        seg_q = '{6'd63, 6'd10, 6'd33, 6'd62, 6'd42, 6'd32, 6'd31};
        wait_drained();

        // Zero control points.
        cp = '0;
        load_ctrl(cp);
        seg_q = '{6'd21, 6'd8};
        wait_drained();

        // Random phases, each with a fresh setting; one phase runs without gaps.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph % 3)
                1:       cp = pick_ctrl(PTS_EXTREME);
                2:       cp = pick_ctrl(PTS_NEAR_ZERO);
                default: cp = pick_ctrl(PTS_RANDOM);
            endcase
            load_ctrl(cp);
            no_gaps = (ph == 3);
            taken = 0;
            while (taken < 55)
            begin
                if ($urandom_range(99) < 5)
                    seg_q.push_back('0);
                else
                begin
                    seg_q.push_back(6'($urandom_range(63, 1)));
                    taken++;
                end
            end
            wait_drained();
            no_gaps = 1'b0;
        end

        if (point_q.size() != 0)
        begin
            $error("%0d points never arrived", point_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
